>>> hw/rtl/gisi_pkg.sv
package gisi_pkg;

  localparam int MAX_BINS_X = 64;
  localparam int MAX_BINS_Y = 64;
  localparam int MAX_BINS   = (MAX_BINS_X > MAX_BINS_Y) ? MAX_BINS_X : MAX_BINS_Y;
  localparam int DEPTH      = MAX_BINS_X * MAX_BINS_Y;
  localparam int ADDR_W     = $clog2(DEPTH);

  // bin index 0 .. count+1
  localparam int IDX_W  = $clog2(MAX_BINS + 2);
  // quotient bits of the bin search; one extra step flags overflow
  localparam int KB     = $clog2(MAX_BINS);
  localparam int BR_W   = KB + 32;

  // interpolation datapath widths
  localparam int T_W    = IDX_W + 32;
  localparam int NUM_W  = IDX_W + 33;
  localparam int DEN_W  = IDX_W + 32;
  localparam int NUM_LO = NUM_W / 2;
  localparam int NUM_HI = NUM_W - NUM_LO;
  localparam int PP_W   = 33 + NUM_HI;
  localparam int PROD_W = 33 + NUM_W;
  localparam int Q_W    = 34;
  localparam int V_W    = Q_W + 2;
  localparam int CNT_W  = $clog2(Q_W);

  typedef enum logic [2:0] {
    REG_X_MIN   = 3'd0,
    REG_X_WIDTH = 3'd1,
    REG_Y_MIN   = 3'd2,
    REG_Y_WIDTH = 3'd3,
    REG_X_COUNT = 3'd4,
    REG_Y_COUNT = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_ROW_UP = 2'd0,
    PH_ROW_DN = 2'd1,
    PH_COL_UP = 2'd2,
    PH_COL_DN = 2'd3
  } phase_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_BIN_STEP,
    OP_BIN_FIX,
    OP_SINIT,
    OP_SSTEP,
    OP_I_LOAD,
    OP_I_MUL1,
    OP_I_MUL2,
    OP_I_MUL3,
    OP_I_MUL4,
    OP_I_MUL5,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_I_FIN,
    OP_FINAL
  } op_t;

  typedef struct packed {
    op_t    op;
    phase_t phase;
    logic   dir;     // 0: x direction, 1: y direction
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic s_done;
    logic use_x;
    logic use_y;
  } sts_t;

  typedef struct packed {
    logic signed [31:0] x_min;
    logic [30:0]        x_w;
    logic signed [31:0] y_min;
    logic [30:0]        y_w;
    logic [IDX_W-1:0]   x_n;
    logic [IDX_W-1:0]   y_n;
  } cfg_t;

endpackage

>>> hw/rtl/grid_interpolate_skip_empty_core.sv
// channel  | handshake             | payload
// ---------+-----------------------+--------------------------------------------------
// in       | in_valid / in_ready   | func, write_column, write_row, write_value,
//          |                       | query_x, query_y
// out      | out_valid / out_ready | interpolated, row_used, column_used
// cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A query raises out_valid after the bin search, the four row/column scans (one bin store read
// per cycle), the direction pick and the write of the result register. Each interpolated
// direction adds the forming of its operands and 34 divide steps.
// After reset the bin store is cleared one entry per cycle while in_ready is low.
// One item at a time; a result waits in the output register and in_ready stays low until taken.
module grid_interpolate_skip_empty_core
  import gisi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic [6:0]         write_column,
  input  logic [6:0]         write_row,
  input  logic signed [31:0] write_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] interpolated,
  output logic               row_used,
  output logic               column_used,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  gisi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gisi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gisi_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .func         (func),
    .write_column (write_column),
    .write_row    (write_row),
    .write_value  (write_value),
    .query_x      (query_x),
    .query_y      (query_y),
    .interpolated (interpolated),
    .row_used     (row_used),
    .column_used  (column_used)
  );

endmodule

>>> hw/rtl/gisi_cfg.sv
module gisi_cfg
  import gisi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  logic [31:0] x_min, y_min;
  logic [30:0] x_w, y_w;
  logic [6:0]  x_cnt, y_cnt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= '0;
      y_min <= '0;
      x_w   <= 31'd65536;
      y_w   <= 31'd65536;
      x_cnt <= 7'd64;
      y_cnt <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_MIN:   x_min <= cfg_data;
        REG_X_WIDTH: x_w   <= cfg_data[30:0];
        REG_Y_MIN:   y_min <= cfg_data;
        REG_Y_WIDTH: y_w   <= cfg_data[30:0];
        REG_X_COUNT: x_cnt <= cfg_data[6:0];
        REG_Y_COUNT: y_cnt <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one; counts clamp to 1 .. max
  always_comb begin
    cfg.x_min = x_min;
    cfg.y_min = y_min;
    cfg.x_w   = (x_w == '0) ? 31'd1 : x_w;
    cfg.y_w   = (y_w == '0) ? 31'd1 : y_w;
    if (x_cnt == '0) begin
      cfg.x_n = IDX_W'(1);
    end else if (32'(x_cnt) > 32'(MAX_BINS_X)) begin
      cfg.x_n = IDX_W'(MAX_BINS_X);
    end else begin
      cfg.x_n = IDX_W'(x_cnt);
    end
    if (y_cnt == '0) begin
      cfg.y_n = IDX_W'(1);
    end else if (32'(y_cnt) > 32'(MAX_BINS_Y)) begin
      cfg.y_n = IDX_W'(MAX_BINS_Y);
    end else begin
      cfg.y_n = IDX_W'(y_cnt);
    end
  end

endmodule

>>> hw/rtl/gisi_ctrl.sv
module gisi_ctrl
  import gisi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic func,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN,
    S_BINFIX,
    S_SINIT,
    S_SRUN,
    S_PICK,
    S_ILOAD,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_DIVI,
    S_DIV,
    S_IFIN,
    S_FINAL,
    S_OUT
  } state_t;

  state_t           state;
  phase_t           phase;
  logic             dir;
  logic [CNT_W-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.phase = phase;
    cmd.dir   = dir;
    unique case (state)
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_IDLE:   cmd.op = OP_ACCEPT;
      S_BIN:    cmd.op = OP_BIN_STEP;
      S_BINFIX: cmd.op = OP_BIN_FIX;
      S_SINIT:  cmd.op = OP_SINIT;
      S_SRUN:   cmd.op = OP_SSTEP;
      S_ILOAD:  cmd.op = OP_I_LOAD;
      S_M1:     cmd.op = OP_I_MUL1;
      S_M2:     cmd.op = OP_I_MUL2;
      S_M3:     cmd.op = OP_I_MUL3;
      S_M4:     cmd.op = OP_I_MUL4;
      S_M5:     cmd.op = OP_I_MUL5;
      S_DIVI:   cmd.op = OP_DIV_INIT;
      S_DIV:    cmd.op = OP_DIV_STEP;
      S_IFIN:   cmd.op = OP_I_FIN;
      S_FINAL:  cmd.op = OP_FINAL;
      default:  cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      phase     <= PH_ROW_UP;
      dir       <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && func) begin
            cnt   <= CNT_W'(KB);
            state <= S_BIN;
          end
        end
        S_BIN: begin
          if (cnt == '0) begin
            state <= S_BINFIX;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_BINFIX: begin
          phase <= PH_ROW_UP;
          state <= S_SINIT;
        end
        S_SINIT: state <= S_SRUN;
        S_SRUN: begin
          if (sts.s_done) begin
            unique case (phase)
              PH_ROW_UP: begin phase <= PH_ROW_DN; state <= S_SINIT; end
              PH_ROW_DN: begin phase <= PH_COL_UP; state <= S_SINIT; end
              PH_COL_UP: begin phase <= PH_COL_DN; state <= S_SINIT; end
              PH_COL_DN: state <= S_PICK;
              default:   state <= S_PICK;
            endcase
          end
        end
        S_PICK: begin
          if (sts.use_x) begin
            dir   <= 1'b0;
            state <= S_ILOAD;
          end else if (sts.use_y) begin
            dir   <= 1'b1;
            state <= S_ILOAD;
          end else begin
            state <= S_FINAL;
          end
        end
        S_ILOAD: state <= S_M1;
        S_M1:    state <= S_M2;
        S_M2:    state <= S_M3;
        S_M3:    state <= S_M4;
        S_M4:    state <= S_M5;
        S_M5:    state <= S_DIVI;
        S_DIVI: begin
          cnt   <= CNT_W'(Q_W - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_IFIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_IFIN: begin
          if (!dir && sts.use_y) begin
            dir   <= 1'b1;
            state <= S_ILOAD;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_in_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result shown outside output state");
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func |=> !in_ready && !out_valid)
    else $error("query transfer did not start processing");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt <= CNT_W'(Q_W - 1)) else $error("divide step count out of range");
`endif

endmodule

>>> hw/rtl/gisi_dp.sv
module gisi_dp
  import gisi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  cfg_t               cfg,
  input  logic               in_valid,
  input  logic               func,
  input  logic [6:0]         write_column,
  input  logic [6:0]         write_row,
  input  logic signed [31:0] write_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  output logic signed [31:0] interpolated,
  output logic               row_used,
  output logic               column_used
);

  // bin store
  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr, clr_addr;
  logic [31:0]       wdata;
  logic              wr_ok;

  // bin finding
  logic signed [32:0] dx, dy, qdx, qdy;
  logic [BR_W-1:0]    brem_x, brem_y, wsh_x, wsh_y;
  logic [KB:0]        kx, ky;
  logic [IDX_W-1:0]   bx, by;

  // search
  logic [IDX_W-1:0]   cnt, pidx, col_i, row_i, lim_n, fix, fix_n;
  logic               pend, is_row, is_up, fix_ok, in_rng, hit_now;
  logic               hit  [4];
  logic [IDX_W-1:0]   hidx [4];
  logic signed [31:0] hval [4];

  // interpolation
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic               neg;
  logic [IDX_W:0]     bm;
  logic [IDX_W-1:0]   ab;
  logic [31:0]        dr;
  logic [30:0]        wr;
  logic signed [31:0] cbr;
  logic [T_W-1:0]     t;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [PP_W-1:0]    pp;
  logic [PROD_W-1:0]  prod;
  logic [DEN_W-1:0]   rem;
  logic [Q_W-1:0]     dvd, q;
  logic [DEN_W:0]     r2;
  logic               ge;
  logic signed [V_W-1:0] vx, vy, vnew, cbx, qv, rb;
  logic signed [V_W:0]   vsum;
  logic                  use_x, use_y;

  function automatic logic [IDX_W-1:0] bin_of(input logic neg_d, input logic [KB:0] k,
                                               input logic [IDX_W-1:0] n);
    logic [KB+1:0] kw, nw;
    kw = {1'b0, k};
    nw = (KB+2)'(n);
    if (neg_d) return '0;
    if (k[KB] || kw >= nw) return n + IDX_W'(1);
    return IDX_W'(kw + (KB+2)'(1));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [V_W-1:0] v);
    if (v > V_W'(signed'(32'sh7fffffff)))  return 32'sh7fffffff;
    if (v < V_W'(signed'(-32'sh80000000))) return -32'sh80000000;
    return v[31:0];
  endfunction

  assign qdx = {query_x[31], query_x} - {cfg.x_min[31], cfg.x_min};
  assign qdy = {query_y[31], query_y} - {cfg.y_min[31], cfg.y_min};

  // search address generation
  assign is_row = (cmd.phase == PH_ROW_UP) || (cmd.phase == PH_ROW_DN);
  assign is_up  = (cmd.phase == PH_ROW_UP) || (cmd.phase == PH_COL_UP);
  assign lim_n  = is_row ? cfg.x_n : cfg.y_n;
  assign fix    = is_row ? by : bx;
  assign fix_n  = is_row ? cfg.y_n : cfg.x_n;
  assign fix_ok = (fix != '0) && (fix <= fix_n);
  assign in_rng = fix_ok && (cnt != '0) && (cnt <= lim_n);
  assign col_i  = is_row ? cnt : bx;
  assign row_i  = is_row ? by : cnt;
  assign hit_now = pend && (rdata != '0);

  assign wr_ok = (write_column != '0) && (32'(write_column) <= 32'(MAX_BINS_X)) &&
                 (write_row != '0) && (32'(write_row) <= 32'(MAX_BINS_Y));

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    if (cmd.op == OP_CLEAR) begin
      we = 1'b1;
    end else if (cmd.op == OP_ACCEPT && in_valid && !func && wr_ok) begin
      we    = 1'b1;
      waddr = ADDR_W'((32'(write_row) - 32'd1) * 32'(MAX_BINS_X) +
                      32'(write_column) - 32'd1);
      wdata = write_value;
    end
    re    = (cmd.op == OP_SSTEP) && !hit_now && in_rng;
    raddr = ADDR_W'((32'(row_i) - 32'd1) * 32'(MAX_BINS_X) + 32'(col_i) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign use_x = hit[PH_ROW_UP] && hit[PH_ROW_DN];
  assign use_y = hit[PH_COL_UP] && hit[PH_COL_DN];

  always_comb begin
    sts.clr_last = (clr_addr == ADDR_W'(DEPTH - 1));
    sts.s_done   = hit_now || !in_rng;
    sts.use_x    = use_x;
    sts.use_y    = use_y;
  end

  // divide step and final value
  assign r2   = {rem, dvd[Q_W-1]};
  assign ge   = r2 >= {1'b0, den};
  assign cbx  = V_W'(cbr);
  assign qv   = signed'(V_W'(q));
  assign rb   = (rem != '0) ? V_W'(signed'(2'sd1)) : '0;
  assign vnew = neg ? cbx - qv - rb : cbx + qv;
  assign vsum = {vx[V_W-1], vx} + {vy[V_W-1], vy};

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_SINIT: pend <= 1'b0;
        OP_SSTEP: pend <= re;
        default:  pend <= pend;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        if (in_valid && func) begin
          dx     <= qdx;
          dy     <= qdy;
          brem_x <= BR_W'(qdx[31:0]);
          brem_y <= BR_W'(qdy[31:0]);
          wsh_x  <= BR_W'(cfg.x_w) << KB;
          wsh_y  <= BR_W'(cfg.y_w) << KB;
          kx     <= '0;
          ky     <= '0;
        end
      end
      OP_BIN_STEP: begin
        if (brem_x >= wsh_x) begin
          brem_x <= brem_x - wsh_x;
          kx     <= {kx[KB-1:0], 1'b1};
        end else begin
          kx     <= {kx[KB-1:0], 1'b0};
        end
        if (brem_y >= wsh_y) begin
          brem_y <= brem_y - wsh_y;
          ky     <= {ky[KB-1:0], 1'b1};
        end else begin
          ky     <= {ky[KB-1:0], 1'b0};
        end
        wsh_x <= wsh_x >> 1;
        wsh_y <= wsh_y >> 1;
      end
      OP_BIN_FIX: begin
        bx <= bin_of(dx[32], kx, cfg.x_n);
        by <= bin_of(dy[32], ky, cfg.y_n);
      end
      OP_SINIT: begin
        if (is_up) begin
          cnt <= is_row ? bx : by;
        end else begin
          cnt <= (is_row ? bx : by) - 1'b1;
        end
      end
      OP_SSTEP: begin
        if (hit_now) begin
          hit[cmd.phase]  <= 1'b1;
          hidx[cmd.phase] <= pidx;
          hval[cmd.phase] <= rdata;
        end else if (in_rng) begin
          pidx <= cnt;
          cnt  <= is_up ? cnt + 1'b1 : cnt - 1'b1;
        end else begin
          hit[cmd.phase] <= 1'b0;
        end
      end
      OP_I_LOAD: begin
        if (!cmd.dir) begin
          diff <= {hval[PH_ROW_UP][31], hval[PH_ROW_UP]} - {hval[PH_ROW_DN][31], hval[PH_ROW_DN]};
          bm   <= {hidx[PH_ROW_DN], 1'b0} - (IDX_W+1)'(1);
          ab   <= hidx[PH_ROW_UP] - hidx[PH_ROW_DN];
          cbr  <= hval[PH_ROW_DN];
          dr   <= dx[31:0];
          wr   <= cfg.x_w;
        end else begin
          diff <= {hval[PH_COL_UP][31], hval[PH_COL_UP]} - {hval[PH_COL_DN][31], hval[PH_COL_DN]};
          bm   <= {hidx[PH_COL_DN], 1'b0} - (IDX_W+1)'(1);
          ab   <= hidx[PH_COL_UP] - hidx[PH_COL_DN];
          cbr  <= hval[PH_COL_DN];
          dr   <= dy[31:0];
          wr   <= cfg.y_w;
        end
      end
      OP_I_MUL1: begin
        t   <= T_W'(bm) * T_W'(wr);
        neg <= diff[32];
        mag <= diff[32] ? 33'(-diff) : 33'(diff);
      end
      OP_I_MUL2: begin
        // numerator is positive whenever both neighbours exist
        num <= NUM_W'({dr, 1'b0}) - NUM_W'(t);
        t   <= T_W'(ab) * T_W'(wr);
      end
      OP_I_MUL3: begin
        den <= DEN_W'({t, 1'b0});
        pp  <= PP_W'(mag) * PP_W'(num[NUM_LO-1:0]);
      end
      OP_I_MUL4: begin
        prod <= PROD_W'(pp);
        pp   <= PP_W'(mag) * PP_W'(num[NUM_W-1:NUM_LO]);
      end
      OP_I_MUL5: begin
        prod <= prod + (PROD_W'(pp) << NUM_LO);
      end
      OP_DIV_INIT: begin
        rem <= prod[PROD_W-1:Q_W];
        dvd <= prod[Q_W-1:0];
        q   <= '0;
      end
      OP_DIV_STEP: begin
        rem <= ge ? DEN_W'(r2 - {1'b0, den}) : r2[DEN_W-1:0];
        dvd <= {dvd[Q_W-2:0], 1'b0};
        q   <= {q[Q_W-2:0], ge};
      end
      OP_I_FIN: begin
        if (!cmd.dir) begin
          vx <= vnew;
        end else begin
          vy <= vnew;
        end
      end
      OP_FINAL: begin
        row_used    <= use_x;
        column_used <= use_y;
        if (use_x && use_y) begin
          interpolated <= sat32(vsum[V_W:1]);
        end else if (use_x) begin
          interpolated <= sat32(vx);
        end else if (use_y) begin
          interpolated <= sat32(vy);
        end else begin
          interpolated <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
